// ----- rtl/crbf_pkg.sv -----
// types and constants shared by the cubic rbf pipeline
`timescale 1ns / 1ps
package crbf_pkg;
   localparam int IN_W   = 16;
   localparam int P_W    = 17;
   localparam int SQ_W   = 34;
   localparam int SUM_W  = 36;
   localparam int ROOT_W = 18;
   localparam int REM_W  = 20;
   localparam int NN_W   = 36;
   localparam int NUM_W  = 38;
   localparam int Q_W    = 21;
   localparam int DREM_W = 19;
   localparam int LANES  = 6;
   localparam int PHI_W  = 35;
   localparam int GRAD_W = 28;
   localparam int HESS_W = 21;

   typedef struct packed {
      logic                    valid;
      logic [SUM_W-1:0]        rad;
      logic [ROOT_W-1:0]       root;
      logic [REM_W-1:0]        rem;
      logic signed [P_W-1:0]   px;
      logic signed [P_W-1:0]   py;
      logic signed [P_W-1:0]   pz;
   } sq_type;

   typedef struct packed {
      logic                           valid;
      logic [ROOT_W-1:0]              n;
      logic [LANES-1:0][DREM_W-1:0]   rem;
      logic [LANES-1:0][Q_W-1:0]      nq;
      logic [LANES-1:0]               neg;
      logic                           zero;
      logic [PHI_W-1:0]               phi;
      logic [GRAD_W-1:0]              gx;
      logic [GRAD_W-1:0]              gy;
      logic [GRAD_W-1:0]              gz;
   } dv_type;
endpackage

// ----- rtl/crbf_req_if.sv -----
// request and response channel interfaces
`timescale 1ns / 1ps
interface crbf_req_if;
   logic                 valid;
   logic                 ready;
   logic signed [15:0]   center_x;
   logic signed [15:0]   center_y;
   logic signed [15:0]   center_z;
   logic signed [15:0]   vertex_x;
   logic signed [15:0]   vertex_y;
   logic signed [15:0]   vertex_z;
   modport source (output valid, center_x, center_y, center_z, vertex_x, vertex_y, vertex_z,
                   input ready);
   modport sink (input valid, center_x, center_y, center_z, vertex_x, vertex_y, vertex_z,
                 output ready);
endinterface

interface crbf_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [34:0]          phi_value;
   logic signed [27:0]   grad_x;
   logic signed [27:0]   grad_y;
   logic signed [27:0]   grad_z;
   logic signed [20:0]   h_xx;
   logic signed [20:0]   h_xy;
   logic signed [20:0]   h_xz;
   logic signed [20:0]   h_yy;
   logic signed [20:0]   h_yz;
   logic signed [20:0]   h_zz;
   modport source (output valid, phi_value, grad_x, grad_y, grad_z,
                   h_xx, h_xy, h_xz, h_yy, h_yz, h_zz, input ready);
   modport sink (input valid, phi_value, grad_x, grad_y, grad_z,
                 h_xx, h_xy, h_xz, h_yy, h_yz, h_zz, output ready);
endinterface

// ----- rtl/crbf_sqrt_cell.sv -----
// one square root cell: resolves one root bit from two radicand bits
`timescale 1ns / 1ps
module crbf_sqrt_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  crbf_pkg::sq_type d_in,
   output crbf_pkg::sq_type d_out
);
   import crbf_pkg::*;

   sq_type            q_ff;
   sq_type            q_in;
   logic [REM_W-1:0]  r2;
   logic [REM_W-1:0]  trial;
   logic              ge;

   always_comb begin
      r2    = {d_in.rem[REM_W-3:0], d_in.rad[SUM_W-1:SUM_W-2]};
      trial = {d_in.root, 2'b01};
      ge    = (r2 >= trial);
      q_in      = d_in;
      q_in.rem  = ge ? (r2 - trial) : r2;
      q_in.root = {d_in.root[ROOT_W-2:0], ge};
      q_in.rad  = {d_in.rad[SUM_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;
endmodule

// ----- rtl/crbf_div_cell.sv -----
// one divider cell: one quotient bit for each of the six hessian lanes
`timescale 1ns / 1ps
module crbf_div_cell (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  crbf_pkg::dv_type d_in,
   output crbf_pkg::dv_type d_out
);
   import crbf_pkg::*;

   dv_type             q_ff;
   dv_type             q_in;
   logic [DREM_W-1:0]  r2 [LANES];
   logic [LANES-1:0]   ge;

   always_comb begin
      q_in = d_in;
      for (int i = 0; i < LANES; i++) begin
         r2[i] = {d_in.rem[i][DREM_W-2:0], d_in.nq[i][Q_W-1]};
         ge[i] = (r2[i] >= {1'b0, d_in.n});
         q_in.rem[i] = ge[i] ? (r2[i] - {1'b0, d_in.n}) : r2[i];
         q_in.nq[i]  = {d_in.nq[i][Q_W-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else if (adv) begin
         q_ff <= q_in;
      end
   end

   assign d_out = q_ff;
endmodule

// ----- rtl/cubic_rbf_value_gradient_hessian.sv -----
// top level: cubic rbf value, gradient and hessian pipeline
//
// req_bus carries a center and a vertex (signed Q7.8); rsp_bus returns one beat per
// request beat with n^3, the gradient 3*p*n and the six hessian entries 3*(n^2*I+p*p')/n.
// both channels use valid/ready; a beat moves when both are high.
// the stages are difference, squares, an 18-cell square root chain,
// two multiply stages and a 21-cell divider chain with six lanes per cell.
// throughput is one beat per cycle; a new beat enters every cycle while the
// output register is empty or being taken.
// when rsp_bus stalls, the whole pipeline holds and req_bus.ready drops;
// beats already inside are kept, none are lost or repeated.
// reset clears every stage valid bit; the pipeline is empty afterwards.
// a zero length gives zero value, gradient and hessian.
`timescale 1ns / 1ps
module cubic_rbf_value_gradient_hessian (
   input  logic clock,
   input  logic reset,
   crbf_req_if.sink   req_bus,
   crbf_rsp_if.source rsp_bus
);
   import crbf_pkg::*;

   logic adv;

   logic                   a_valid_ff;
   logic signed [P_W-1:0]  px_ff, py_ff, pz_ff;

   logic                   b_valid_ff;
   logic signed [P_W-1:0]  bx_ff, by_ff, bz_ff;
   logic [SQ_W-1:0]        sx_ff, sy_ff, sz_ff;

   sq_type sq_link [ROOT_W+1];

   logic                     m_valid_ff;
   logic [ROOT_W-1:0]        mn_ff;
   logic [NN_W-1:0]          nn_ff;
   logic signed [SQ_W-1:0]   pxx_ff, pyy_ff, pzz_ff, pxy_ff, pxz_ff, pyz_ff;
   logic signed [P_W+ROOT_W:0] pnx_ff, pny_ff, pnz_ff;
   logic [ROOT_W-1:0]        nsq;

   logic                       c_valid_ff;
   logic [ROOT_W-1:0]          cn_ff;
   logic [NN_W-1:0]            lo_ff, hi_ff;
   logic [LANES-1:0][NUM_W-1:0] mag_ff;
   logic [LANES-1:0]           neg_ff;
   logic [GRAD_W-1:0]          gx_ff, gy_ff, gz_ff;

   logic [NUM_W-1:0]           diag [3];
   logic signed [NUM_W-1:0]    offd [3];
   logic signed [P_W+ROOT_W+2:0] gfull [3];
   logic signed [P_W+ROOT_W+2:0] gtr [3];
   logic [53:0]                phi_sum;

   dv_type dv_link [Q_W+1];
   dv_type last;

   assign last    = dv_link[Q_W];
   assign adv     = !last.valid || rsp_bus.ready;
   assign req_bus.ready = adv;

   // difference stage
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_bus.valid;
      end
      if (adv) begin
         px_ff <= P_W'($signed(req_bus.vertex_x)) - P_W'($signed(req_bus.center_x));
         py_ff <= P_W'($signed(req_bus.vertex_y)) - P_W'($signed(req_bus.center_y));
         pz_ff <= P_W'($signed(req_bus.vertex_z)) - P_W'($signed(req_bus.center_z));
      end
   end

   // squares
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
      if (adv) begin
         bx_ff <= px_ff;
         by_ff <= py_ff;
         bz_ff <= pz_ff;
         sx_ff <= SQ_W'(px_ff * px_ff);
         sy_ff <= SQ_W'(py_ff * py_ff);
         sz_ff <= SQ_W'(pz_ff * pz_ff);
      end
   end

   always_comb begin
      sq_link[0].valid = b_valid_ff;
      sq_link[0].rad   = SUM_W'(sx_ff) + SUM_W'(sy_ff) + SUM_W'(sz_ff);
      sq_link[0].root  = '0;
      sq_link[0].rem   = '0;
      sq_link[0].px    = bx_ff;
      sq_link[0].py    = by_ff;
      sq_link[0].pz    = bz_ff;
   end

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      crbf_sqrt_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .d_in  (sq_link[k]),
         .d_out (sq_link[k+1])
      );
   end

   assign nsq = sq_link[ROOT_W].root;

   // products
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (adv) begin
         m_valid_ff <= sq_link[ROOT_W].valid;
      end
      if (adv) begin
         mn_ff  <= nsq;
         nn_ff  <= nsq * nsq;
         pxx_ff <= sq_link[ROOT_W].px * sq_link[ROOT_W].px;
         pyy_ff <= sq_link[ROOT_W].py * sq_link[ROOT_W].py;
         pzz_ff <= sq_link[ROOT_W].pz * sq_link[ROOT_W].pz;
         pxy_ff <= sq_link[ROOT_W].px * sq_link[ROOT_W].py;
         pxz_ff <= sq_link[ROOT_W].px * sq_link[ROOT_W].pz;
         pyz_ff <= sq_link[ROOT_W].py * sq_link[ROOT_W].pz;
         pnx_ff <= (P_W+ROOT_W+1)'(sq_link[ROOT_W].px * $signed({1'b0, nsq}));
         pny_ff <= (P_W+ROOT_W+1)'(sq_link[ROOT_W].py * $signed({1'b0, nsq}));
         pnz_ff <= (P_W+ROOT_W+1)'(sq_link[ROOT_W].pz * $signed({1'b0, nsq}));
      end
   end

   always_comb begin
      diag[0] = NUM_W'(nn_ff) + NUM_W'(pxx_ff[SQ_W-1:0]);
      diag[1] = NUM_W'(nn_ff) + NUM_W'(pyy_ff[SQ_W-1:0]);
      diag[2] = NUM_W'(nn_ff) + NUM_W'(pzz_ff[SQ_W-1:0]);
      offd[0] = NUM_W'(pxy_ff);
      offd[1] = NUM_W'(pxz_ff);
      offd[2] = NUM_W'(pyz_ff);
      gfull[0] = (P_W+ROOT_W+3)'(pnx_ff);
      gfull[1] = (P_W+ROOT_W+3)'(pny_ff);
      gfull[2] = (P_W+ROOT_W+3)'(pnz_ff);
      for (int i = 0; i < 3; i++) begin
         diag[i]  = (diag[i] << 1) + diag[i];
         offd[i]  = (offd[i] <<< 1) + offd[i];
         gfull[i] = (gfull[i] <<< 1) + gfull[i];
         gtr[i]   = (gfull[i] + (gfull[i][P_W+ROOT_W+2] ? (P_W+ROOT_W+3)'(255)
                                                         : (P_W+ROOT_W+3)'(0))) >>> 8;
      end
   end

   // numerators and cube partials
   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= m_valid_ff;
      end
      if (adv) begin
         cn_ff  <= mn_ff;
         lo_ff  <= NN_W'(nn_ff[ROOT_W-1:0] * mn_ff);
         hi_ff  <= NN_W'(nn_ff[NN_W-1:ROOT_W] * mn_ff);
         mag_ff[0] <= diag[0];
         mag_ff[1] <= offd[0][NUM_W-1] ? NUM_W'(-offd[0]) : NUM_W'(offd[0]);
         mag_ff[2] <= offd[1][NUM_W-1] ? NUM_W'(-offd[1]) : NUM_W'(offd[1]);
         mag_ff[3] <= diag[1];
         mag_ff[4] <= offd[2][NUM_W-1] ? NUM_W'(-offd[2]) : NUM_W'(offd[2]);
         mag_ff[5] <= diag[2];
         neg_ff <= {1'b0, offd[2][NUM_W-1], 1'b0, offd[1][NUM_W-1], offd[0][NUM_W-1], 1'b0};
         gx_ff  <= gtr[0][GRAD_W-1:0];
         gy_ff  <= gtr[1][GRAD_W-1:0];
         gz_ff  <= gtr[2][GRAD_W-1:0];
      end
   end

   assign phi_sum = {hi_ff, 18'b0} + 54'(lo_ff);

   always_comb begin
      dv_link[0].valid = c_valid_ff;
      dv_link[0].n     = cn_ff;
      dv_link[0].zero  = (cn_ff == '0);
      dv_link[0].phi   = phi_sum[PHI_W+15:16];
      dv_link[0].gx    = gx_ff;
      dv_link[0].gy    = gy_ff;
      dv_link[0].gz    = gz_ff;
      dv_link[0].neg   = neg_ff;
      for (int i = 0; i < LANES; i++) begin
         dv_link[0].rem[i] = DREM_W'(mag_ff[i][NUM_W-1:Q_W]);
         dv_link[0].nq[i]  = mag_ff[i][Q_W-1:0];
      end
   end

   for (genvar k = 0; k < Q_W; k++) begin : g_div
      crbf_div_cell u_cell (
         .clock (clock),
         .reset (reset),
         .adv   (adv),
         .d_in  (dv_link[k]),
         .d_out (dv_link[k+1])
      );
   end

   logic [HESS_W-1:0] hq [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (last.zero) begin
            hq[i] = '0;
         end else if (last.neg[i]) begin
            hq[i] = HESS_W'(-last.nq[i]);
         end else begin
            hq[i] = HESS_W'(last.nq[i]);
         end
      end
   end

   assign rsp_bus.valid     = last.valid;
   assign rsp_bus.phi_value = last.zero ? '0 : last.phi;
   assign rsp_bus.grad_x    = last.gx;
   assign rsp_bus.grad_y    = last.gy;
   assign rsp_bus.grad_z    = last.gz;
   assign rsp_bus.h_xx      = hq[0];
   assign rsp_bus.h_xy      = hq[1];
   assign rsp_bus.h_xz      = hq[2];
   assign rsp_bus.h_yy      = hq[3];
   assign rsp_bus.h_yz      = hq[4];
   assign rsp_bus.h_zz      = hq[5];
endmodule
